// ===== sv/rshp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rshp_pkg
// Shared types and constants for the streaming RGB 3x3 sharpen filter.
// ----------------------------------------------------------------------------
package rshp_pkg;

    localparam int RSHP_MAX_WIDTH = 1024;

    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 16;
    localparam int IN_TW    = 24;
    localparam int OUT_TW   = 64;
    localparam int N_LANES  = 4;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd1;

    // Packed pixel: red in the top byte, blue in the bottom byte
    typedef logic [23:0] t_pix;

    typedef logic signed [11:0] t_val;

    // Position of a request and the border tests derived from it
    typedef struct packed {
        logic [15:0] row;
        logic [9:0]  col;
        logic        r_ge1;
        logic        r_is1;
        logic        c_ge1;
        logic        c_is1;
        logic        c_last;
        logic        w_one;
        logic        last;
    } t_pos;

    typedef struct packed {
        logic [15:0] row;
        logic [9:0]  col;
        t_val        red;
        t_val        green;
        t_val        blue;
        logic        done;
    } t_res;

    // One group of up to four results handed to the merge stage
    typedef struct packed {
        logic [N_LANES-1:0] mask;
        t_res [N_LANES-1:0] res;
    } t_bundle;

endpackage

// ===== sv/rgb_sharpen_3x3_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_stream
// Streaming 3x3 sharpen filter on RGB pixels in raster order, with edge
// replication at the borders and signed, unclamped results.
// ----------------------------------------------------------------------------
// Channel  | Direction | Content
// s_axis   | in        | tdata: red, green, blue (8 bit each)
// m_axis   | out       | tdata: row, col, red, green, blue; tlast: image end
// i_cfg    | in        | 0: image width, 1: image height
//
// One request is accepted per cycle unless the pipeline stalls. A request is
// registered with its line store data and then enters the window; up to four
// results follow it, held in the merge and sent one per cycle through the
// output register while m_axis_tready allows; the input stalls as they drain.
// The line store is read once and written once per request.
// Reset is synchronous; the line store is not cleared, as no entry is used
// before the current image has written it.
// ----------------------------------------------------------------------------
module rgb_sharpen_3x3_stream
    import rshp_pkg::*;
#(
    parameter int MAX_WIDTH = RSHP_MAX_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata,   // [15:0] row, [25:16] col, [37:26] red,
                                              // [49:38] green, [61:50] blue, zero above
    output logic              m_axis_tlast    // image done
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    function automatic logic [AW-1:0] f_wlast(input logic [10:0] w);
        begin
            if (w == 11'd0) begin
                f_wlast = '0;
            end else if (int'(w) > MAX_WIDTH) begin
                f_wlast = AW'(MAX_WIDTH - 1);
            end else begin
                f_wlast = AW'(w - 11'd1);
            end
        end
    endfunction

    // Configuration and input position
    logic [AW-1:0] r_wlast;
    logic [15:0]   r_hlast;
    logic [AW-1:0] r_col;
    logic [15:0]   r_row;
    logic          accept;
    logic          at_col_end;
    logic          at_row_end;
    t_pos          in_pos;

    // Stage 1: request waiting for its line store data
    logic          r_s1_vld;
    t_pix          r_s1_pix;
    logic [AW-1:0] r_s1_addr;
    t_pos          r_s1_pos;
    logic [47:0]   rd_data;
    logic          s1_move;

    // Stage 2: window in place, lanes working
    logic          r_s2_vld;
    t_pos          r_s2_pos;
    t_pix          r_win [0:2][0:2];   // [column old..new][row top, mid, bottom]
    logic          s2_adv;
    logic          s3_free;
    logic          s3_load;
    t_bundle       bundle;

    t_pix          l_ctr [N_LANES];
    t_pix          l_up  [N_LANES];
    t_pix          l_dn  [N_LANES];
    t_pix          l_lf  [N_LANES];
    t_pix          l_rt  [N_LANES];
    t_val          l_red [N_LANES];
    t_val          l_grn [N_LANES];
    t_val          l_blu [N_LANES];

    assign at_col_end = (r_col == r_wlast);
    assign at_row_end = (r_row == r_hlast);

    assign s_axis_tready = !r_s1_vld || s2_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_pos.row    = r_row;
        in_pos.col    = 10'(r_col);
        in_pos.r_ge1  = (r_row != 16'd0);
        in_pos.r_is1  = (r_row == 16'd1);
        in_pos.c_ge1  = (r_col != '0);
        in_pos.c_is1  = (r_col == AW'(1));
        in_pos.c_last = at_col_end;
        in_pos.w_one  = (r_wlast == '0);
        in_pos.last   = at_row_end;
    end

    // A write to the width or height register also starts a new image.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= f_wlast(11'd1024);
            r_hlast <= 16'd0;
            r_col   <= '0;
            r_row   <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WIDTH: begin
                    r_wlast <= f_wlast(i_cfg_wdata[10:0]);
                    r_col   <= '0;
                    r_row   <= 16'd0;
                end
                CFG_HEIGHT: begin
                    r_hlast <= (i_cfg_wdata == 16'd0) ? 16'd0 : i_cfg_wdata - 16'd1;
                    r_col   <= '0;
                    r_row   <= 16'd0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (at_col_end) begin
                r_col <= '0;
                r_row <= at_row_end ? 16'd0 : r_row + 16'd1;
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

    assign s1_move = r_s1_vld && s2_adv;

    rshp_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd_data),
        .i_we    (s1_move),
        .i_waddr (r_s1_addr),
        .i_wdata ({rd_data[23:0], r_s1_pix})
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s2_adv) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
            r_s1_addr <= r_col;
            r_s1_pos  <= in_pos;
        end
        if (s1_move) begin
            r_s2_pos <= r_s1_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (s1_move) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2][0] <= rd_data[47:24];
            r_win[2][1] <= rd_data[23:0];
            r_win[2][2] <= r_s1_pix;
        end
    end

    // Lane 0/1: row above, left and current column; lane 2/3: last row.
    always_comb begin
        l_ctr[0] = r_win[1][1];
        l_up[0]  = r_s2_pos.r_is1 ? r_win[1][1] : r_win[1][0];
        l_dn[0]  = r_win[1][2];
        l_lf[0]  = r_s2_pos.c_is1 ? r_win[1][1] : r_win[0][1];
        l_rt[0]  = r_win[2][1];

        l_ctr[1] = r_win[2][1];
        l_up[1]  = r_s2_pos.r_is1 ? r_win[2][1] : r_win[2][0];
        l_dn[1]  = r_win[2][2];
        l_lf[1]  = r_s2_pos.w_one ? r_win[2][1] : r_win[1][1];
        l_rt[1]  = r_win[2][1];

        l_ctr[2] = r_win[1][2];
        l_up[2]  = r_s2_pos.r_ge1 ? r_win[1][1] : r_win[1][2];
        l_dn[2]  = r_win[1][2];
        l_lf[2]  = r_s2_pos.c_is1 ? r_win[1][2] : r_win[0][2];
        l_rt[2]  = r_win[2][2];

        l_ctr[3] = r_win[2][2];
        l_up[3]  = r_s2_pos.r_ge1 ? r_win[2][1] : r_win[2][2];
        l_dn[3]  = r_win[2][2];
        l_lf[3]  = r_s2_pos.w_one ? r_win[2][2] : r_win[1][2];
        l_rt[3]  = r_win[2][2];
    end

    for (genvar g = 0; g < N_LANES; g++) begin : g_lane
        rshp_lane u_lane (
            .i_ctr   (l_ctr[g]),
            .i_up    (l_up[g]),
            .i_dn    (l_dn[g]),
            .i_lf    (l_lf[g]),
            .i_rt    (l_rt[g]),
            .o_red   (l_red[g]),
            .o_green (l_grn[g]),
            .o_blue  (l_blu[g])
        );
    end

    always_comb begin
        bundle.mask[0] = r_s2_pos.r_ge1 && r_s2_pos.c_ge1;
        bundle.mask[1] = r_s2_pos.r_ge1 && r_s2_pos.c_last;
        bundle.mask[2] = r_s2_pos.last && r_s2_pos.c_ge1;
        bundle.mask[3] = r_s2_pos.last && r_s2_pos.c_last;
        for (int k = 0; k < N_LANES; k++) begin
            bundle.res[k].red   = l_red[k];
            bundle.res[k].green = l_grn[k];
            bundle.res[k].blue  = l_blu[k];
            bundle.res[k].done  = 1'b0;
        end
        bundle.res[0].row = r_s2_pos.row - 16'd1;
        bundle.res[0].col = r_s2_pos.col - 10'd1;
        bundle.res[1].row = r_s2_pos.row - 16'd1;
        bundle.res[1].col = r_s2_pos.col;
        bundle.res[2].row = r_s2_pos.row;
        bundle.res[2].col = r_s2_pos.col - 10'd1;
        bundle.res[3].row = r_s2_pos.row;
        bundle.res[3].col = r_s2_pos.col;
        bundle.res[3].done = 1'b1;
    end

    // A request with no results leaves stage 2 without touching the merge.
    assign s3_load = r_s2_vld && (bundle.mask != '0) && s3_free;
    assign s2_adv  = !r_s2_vld || (bundle.mask == '0) || s3_free;

    rshp_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s3_load),
        .i_bundle (bundle),
        .o_free   (s3_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

// ===== sv/rshp_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rshp_line_store
// Two-row line memory, one entry per column: older row above newer row.
// ----------------------------------------------------------------------------
module rshp_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [47:0]   o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [47:0]   i_wdata
);

    logic [47:0] r_mem [0:DEPTH-1];
    logic [47:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // A read that meets a write to the same column takes the new data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rshp_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rshp_lane
// Sharpen kernel for one result pixel on all three channels.
// ----------------------------------------------------------------------------
module rshp_lane
    import rshp_pkg::*;
(
    input  t_pix i_ctr,
    input  t_pix i_up,
    input  t_pix i_dn,
    input  t_pix i_lf,
    input  t_pix i_rt,
    output t_val o_red,
    output t_val o_green,
    output t_val o_blue
);

    // 255 - (5*c - u - d - l - r); the range fits twelve bits exactly.
    function automatic t_val f_kern(input logic [7:0] c, input logic [7:0] u,
                                    input logic [7:0] d, input logic [7:0] l,
                                    input logic [7:0] r);
        logic [11:0] ce;
        logic [11:0] acc;
        begin
            ce  = {4'd0, c};
            acc = 12'd255 - (ce << 2) - ce + {4'd0, u} + {4'd0, d}
                  + {4'd0, l} + {4'd0, r};
            f_kern = t_val'(acc);
        end
    endfunction

    assign o_red   = f_kern(i_ctr[23:16], i_up[23:16], i_dn[23:16],
                            i_lf[23:16], i_rt[23:16]);
    assign o_green = f_kern(i_ctr[15:8], i_up[15:8], i_dn[15:8],
                            i_lf[15:8], i_rt[15:8]);
    assign o_blue  = f_kern(i_ctr[7:0], i_up[7:0], i_dn[7:0],
                            i_lf[7:0], i_rt[7:0]);

endmodule

// ===== sv/rshp_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rshp_merge
// Holds the lane results of one request and sends them out one per cycle while
// i_ready allows, lowest lane first, through the output register.
// ----------------------------------------------------------------------------
module rshp_merge
    import rshp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_bundle           i_bundle,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_TW-1:0] o_data,
    output logic              o_last
);

    logic [N_LANES-1:0] r_mask;
    logic [N_LANES-1:0] n_mask;
    t_res [N_LANES-1:0] r_res;
    t_res               r_out;
    logic               r_out_vld;
    logic               n_out_vld;
    logic               out_take;
    logic               send;
    logic [N_LANES-1:0] sel;
    t_res               sel_res;

    assign out_take = !r_out_vld || i_ready;
    assign send     = (r_mask != '0) && out_take;
    // Lowest set bit of the mask
    assign sel      = r_mask & (~r_mask + N_LANES'(1));

    always_comb begin
        sel_res = r_res[0];
        for (int k = N_LANES - 1; k >= 0; k--) begin
            if (sel[k]) begin
                sel_res = r_res[k];
            end
        end
    end

    // Free when empty, or when its only remaining result leaves this cycle.
    assign o_free = (r_mask == '0) ||
                    (out_take && ((r_mask & (r_mask - N_LANES'(1))) == '0));

    always_comb begin
        n_mask = r_mask;
        if (send) begin
            n_mask = r_mask & ~sel;
        end
        if (i_load) begin
            n_mask = i_bundle.mask;
        end
        n_out_vld = r_out_vld;
        if (send) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_mask    <= n_mask;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_bundle.res;
        end
        if (send) begin
            r_out <= sel_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = {2'b00, r_out.blue, r_out.green, r_out.red, r_out.col, r_out.row};
    assign o_last  = r_out.done;

endmodule
